FILE: design/der_pkg.sv
// Shared types, codes and constant tables of the DER TLV element decoder.
package der_pkg;

  // Default parameter values.
  localparam int unsigned PositionBitsDef   = 32;
  localparam int unsigned MaxLengthBytesDef = 8;
  localparam int unsigned FifoDepthDef      = 2;

  // Field widths.
  localparam int unsigned ActionW = 3;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OidIdxW = 4;
  localparam int unsigned OidCount = 11;
  localparam int unsigned OidMaxLen = 8;

  // Action codes that come with a tag byte.
  localparam logic [ActionW-1:0] ActSeq       = 3'd0;
  localparam logic [ActionW-1:0] ActEnterOct  = 3'd1;
  localparam logic [ActionW-1:0] ActInt       = 3'd2;
  localparam logic [ActionW-1:0] ActOid       = 3'd3;
  localparam logic [ActionW-1:0] ActOctet     = 3'd4;
  localparam logic [ActionW-1:0] ActBitString = 3'd5;

  // Long-form length count field.
  localparam logic [7:0] LongCountMask = 8'h7F;

  // Configuration register byte offsets.
  localparam logic [2:0] RegTotalLength = 3'd0;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_BAD_TAG   = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_OVERRUN   = 3'd3,
    ST_BAD_INT   = 3'd4,
    ST_UNK_OID   = 3'd5,
    ST_EMPTY_BIT = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_LEN1    = 3'd1,
    PH_LENN    = 3'd2,
    PH_BITSKIP = 3'd3,
    PH_CONTENT = 3'd4
  } phase_e;

  // One queued stream byte.
  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [7:0]         stream_byte;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic               result_kind;
    status_e            status;
    logic [7:0]         content_byte;
    logic [63:0]        int_value;
    logic [OidIdxW-1:0] oid_index;
    logic [31:0]        body_length;
  } result_t;

  // Known object identifier table.
  localparam logic [3:0] OID_LEN [OidCount] = '{
    4'd3, 4'd3, 4'd3, 4'd8, 4'd8, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3
  };

  localparam logic [7:0] OID_TAB [OidCount][OidMaxLen] = '{
    '{8'h55, 8'h04, 8'h03, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h65, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h65, 8'h6E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h2B, 8'h06, 8'h01, 8'h05, 8'h05, 8'h07, 8'h03, 8'h01},
    '{8'h2B, 8'h06, 8'h01, 8'h05, 8'h05, 8'h07, 8'h03, 8'h02},
    '{8'h55, 8'h1D, 8'h13, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h25, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h11, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h0E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h55, 8'h1D, 8'h23, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Returns true when the tag byte is the one the action expects.
  function automatic logic tag_matches(logic [ActionW-1:0] act, logic [7:0] tag);
    logic ok;
    ok = 1'b0;
    unique case (act)
      ActSeq:       ok = (tag == 8'h30);
      ActEnterOct:  ok = (tag == 8'h04);
      ActInt:       ok = (tag == 8'h02);
      ActOid:       ok = (tag == 8'h06);
      ActOctet:     ok = (tag == 8'h04);
      ActBitString: ok = (tag == 8'h03);
      default:      ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

FILE: design/der_fifo.sv
// Front queue that accepts stream bytes and holds them for the parser.
module der_fifo #(
  parameter int unsigned DEPTH = der_pkg::FifoDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  der_pkg::item_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output der_pkg::item_t pop_data_o
);
  import der_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  item_t         mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] count_q, count_d;

  assign full_o     = (count_q == CW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

FILE: design/der_parse.sv
// Back end parser: TLV state machine with a registered result stage.
module der_parse #(
  parameter int unsigned POSITION_BITS    = der_pkg::PositionBitsDef,
  parameter int unsigned MAX_LENGTH_BYTES = der_pkg::MaxLengthBytesDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            restart_i,
  input  logic [31:0]     total_length_i,
  input  logic            item_valid_i,
  input  der_pkg::item_t  item_i,
  output logic            item_pop_o,
  output logic            res_valid_o,
  input  logic            res_stall_i,
  output der_pkg::result_t res_o
);
  import der_pkg::*;

  localparam int unsigned PW  = POSITION_BITS;
  localparam int unsigned LW  = 8 * MAX_LENGTH_BYTES;
  localparam int unsigned NW  = $clog2(MAX_LENGTH_BYTES + 1);
  localparam int unsigned MW  = (PW > LW) ? PW : LW;
  localparam int unsigned CW  = ((MW > 32) ? MW : 32) + 2;

  phase_e             phase_q, phase_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [ActionW-1:0] act_q, act_d;
  logic [NW-1:0]      lbl_q, lbl_d;
  logic [LW-1:0]      acc_q, acc_d;
  logic [31:0]        cl_q, cl_d;
  logic [3:0]         ci_q, ci_d;
  logic [63:0]        vacc_q, vacc_d;
  logic [OidCount-1:0] mask_q, mask_d;

  logic               res_valid_q;
  result_t            res_q, res_d;
  logic               emit;
  logic               step;

  logic [PW-1:0]      pos_inc;
  logic [LW-1:0]      len_cand;
  logic [CW-1:0]      len_x, acc_x, total_x, pos_x, pos_inc_x;
  logic [31:0]        len32;
  logic [6:0]         long_n;
  logic               do_done;
  logic [63:0]        ival;
  logic [OidCount-1:0] mask_new;
  logic               oid_hit;
  logic [OidIdxW-1:0] oid_idx;
  logic [7:0]         b;

  assign step        = item_valid_i && (!res_valid_q || !res_stall_i);
  assign item_pop_o  = step;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign b         = item_i.stream_byte;
  assign pos_inc   = pos_q + PW'(1);
  assign len_cand  = (phase_q == PH_LENN) ? LW'((acc_q << 8) | LW'(b)) : LW'(b);
  assign len_x     = CW'(len_cand);
  assign acc_x     = CW'(acc_q);
  assign total_x   = CW'(total_length_i);
  assign pos_x     = CW'(pos_q);
  assign pos_inc_x = CW'(pos_inc);
  assign len32     = len_x[31:0];
  assign long_n    = b[6:0] & LongCountMask[6:0];

  // INTEGER accumulate and sign extension by content length.
  always_comb begin
    ival = {vacc_q[55:0], b};
    for (int k = 1; k < 8; k++) begin
      if (acc_q[3:0] == 4'(k) && ival[8*k-1]) begin
        ival = ival | (~64'd0 << (8 * k));
      end
    end
  end

  // OID candidate filter and first full match.
  always_comb begin
    mask_new = mask_q;
    oid_hit  = 1'b0;
    oid_idx  = '0;
    for (int i = 0; i < OidCount; i++) begin
      if (ci_q >= OID_LEN[i] || OID_TAB[i][ci_q[2:0]] != b) begin
        mask_new[i] = 1'b0;
      end
    end
    for (int i = OidCount - 1; i >= 0; i--) begin
      if (mask_new[i] && acc_x == CW'(OID_LEN[i])) begin
        oid_hit = 1'b1;
        oid_idx = OidIdxW'(i);
      end
    end
  end

  // Next state and result of one parser step.
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    act_d   = act_q;
    lbl_d   = lbl_q;
    acc_d   = acc_q;
    cl_d    = cl_q;
    ci_d    = ci_q;
    vacc_d  = vacc_q;
    mask_d  = mask_q;
    res_d   = '0;
    emit    = 1'b0;
    do_done = 1'b0;

    unique case (phase_q)
      PH_TAG: begin
        if (pos_x >= total_x) begin
          emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OVERRUN;
        end else begin
          pos_d = pos_inc;
          act_d = item_i.action;
          if (!tag_matches(item_i.action, b)) begin
            emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_BAD_TAG;
          end else begin
            phase_d = PH_LEN1;
          end
        end
      end
      PH_LEN1: begin
        if (pos_x >= total_x) begin
          emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OVERRUN;
          phase_d = PH_TAG;
        end else begin
          pos_d = pos_inc;
          if (b[7]) begin
            if (long_n == '0 || 32'(long_n) > 32'(MAX_LENGTH_BYTES)) begin
              emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_BAD_LEN;
              phase_d = PH_TAG;
            end else if (pos_inc_x + CW'(long_n) > total_x) begin
              emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OVERRUN;
              phase_d = PH_TAG;
            end else begin
              lbl_d   = NW'(long_n);
              acc_d   = '0;
              phase_d = PH_LENN;
            end
          end else begin
            do_done = 1'b1;
          end
        end
      end
      PH_LENN: begin
        pos_d = pos_inc;
        acc_d = len_cand;
        lbl_d = lbl_q - NW'(1);
        if (lbl_q == NW'(1)) begin
          do_done = 1'b1;
        end
      end
      PH_BITSKIP: begin
        pos_d = pos_inc;
        if (cl_q == '0) begin
          emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OK;
          phase_d = PH_TAG;
        end else begin
          phase_d = PH_CONTENT;
        end
      end
      PH_CONTENT: begin
        if (cl_q == '0) begin
          phase_d = PH_TAG;
        end else begin
          pos_d = pos_inc;
          cl_d  = cl_q - 32'd1;
          if (act_q == ActInt) begin
            vacc_d = {vacc_q[55:0], b};
            if (cl_q == 32'd1) begin
              phase_d = PH_TAG;
              emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OK;
              res_d.int_value = ival;
              res_d.body_length = acc_x[31:0];
            end
          end else if (act_q == ActOid) begin
            mask_d = mask_new;
            if (ci_q != 4'hF) begin
              ci_d = ci_q + 4'd1;
            end
            if (cl_q == 32'd1) begin
              phase_d = PH_TAG;
              emit = 1'b1; res_d.result_kind = 1'b1;
              if (oid_hit) begin
                res_d.status = ST_OK;
                res_d.oid_index = oid_idx;
                res_d.body_length = acc_x[31:0];
              end else begin
                res_d.status = ST_UNK_OID;
              end
            end
          end else begin
            if (cl_q == 32'd1) begin
              phase_d = PH_TAG;
            end
            emit = 1'b1; res_d.result_kind = 1'b0; res_d.status = ST_OK;
            res_d.content_byte = b;
            res_d.body_length = acc_x[31:0];
          end
        end
      end
      default: begin
        phase_d = PH_TAG;
      end
    endcase

    // Element length known: check it against the buffer, then finish the element or start its content.
    if (do_done) begin
      acc_d = len_cand;
      if (pos_inc_x + len_x > total_x) begin
        emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OVERRUN;
        phase_d = PH_TAG;
      end else begin
        cl_d   = len32;
        ci_d   = '0;
        vacc_d = '0;
        mask_d = '1;
        if (act_q == ActSeq || act_q == ActEnterOct) begin
          phase_d = PH_TAG;
          emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OK;
          res_d.body_length = len32;
        end else if (act_q == ActInt) begin
          if (len_x == '0 || len_x > CW'(8)) begin
            emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_BAD_INT;
            phase_d = PH_TAG;
          end else begin
            phase_d = PH_CONTENT;
          end
        end else if (act_q == ActOid) begin
          if (len_x == '0) begin
            emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_UNK_OID;
            phase_d = PH_TAG;
          end else begin
            phase_d = PH_CONTENT;
          end
        end else if (act_q == ActOctet) begin
          if (len_x == '0) begin
            emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_OK;
            phase_d = PH_TAG;
          end else begin
            phase_d = PH_CONTENT;
          end
        end else begin
          if (len_x == '0) begin
            emit = 1'b1; res_d.result_kind = 1'b1; res_d.status = ST_EMPTY_BIT;
            phase_d = PH_TAG;
          end else begin
            cl_d    = len32 - 32'd1;
            acc_d   = len_cand - LW'(1);
            phase_d = PH_BITSKIP;
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      pos_q   <= '0;
      act_q   <= '0;
      lbl_q   <= '0;
      acc_q   <= '0;
      cl_q    <= '0;
      ci_q    <= '0;
      vacc_q  <= '0;
      mask_q  <= '1;
    end else if (restart_i) begin
      phase_q <= PH_TAG;
      pos_q   <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      act_q   <= act_d;
      lbl_q   <= lbl_d;
      acc_q   <= acc_d;
      cl_q    <= cl_d;
      ci_q    <= ci_d;
      vacc_q  <= vacc_d;
      mask_q  <= mask_d;
    end
  end

  // Result register: loaded by a producing step, cleared once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step) begin
      res_valid_q <= emit;
    end else if (!res_stall_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      res_q <= res_d;
    end
  end

endmodule

FILE: design/der_tlv_element_decoder.sv
// Top level of the DER TLV element decoder.
//
// Input channel: one DER stream byte per transaction (in_valid_i/in_stall_o),
// with action_i naming the expected element on each tag byte. Output channel:
// at most one result per byte (out_valid_o/out_stall_i): a string content
// byte, or a finish/error record with status, INTEGER value, OID index and
// content length.
// Bytes enter a short front queue and a parser state machine takes one byte
// per cycle from it, so the sustained rate is one byte per cycle. A result
// is registered: its byte passes through the front queue and the result
// register before the result is shown on the output.
// The parser advances only while the result register is free or being
// taken; when the receiver stalls, the queue fills and in_stall_o rises.
// Reset empties the queue, clears the result register, sets the position to
// zero, the total length to one and waits for a tag byte.
// Writing total_length over the APB port restarts the position at zero and
// abandons any partly parsed element; write only while the block is idle.
module der_tlv_element_decoder #(
  parameter int unsigned POSITION_BITS    = der_pkg::PositionBitsDef,
  parameter int unsigned MAX_LENGTH_BYTES = der_pkg::MaxLengthBytesDef,
  parameter int unsigned FIFO_DEPTH       = der_pkg::FifoDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          action_i,
  input  logic [7:0]          stream_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                result_kind_o,
  output logic [2:0]          status_o,
  output logic [7:0]          content_byte_o,
  output logic signed [63:0]  int_value_o,
  output logic [3:0]          oid_index_o,
  output logic [31:0]         body_length_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import der_pkg::*;

  logic        total_wr;
  logic [31:0] total_q;
  logic        fifo_full, fifo_valid, pop;
  item_t       in_item, head_item;
  result_t     res;

  // Configuration register.
  assign pready   = 1'b1;
  assign total_wr = psel && penable && pwrite && (paddr[2] == RegTotalLength[2]);
  assign prdata   = (paddr[2] == RegTotalLength[2]) ? total_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= 32'd1;
    end else if (total_wr) begin
      total_q <= pwdata;
    end
  end

  assign in_item.action      = action_i;
  assign in_item.stream_byte = stream_byte_i;
  assign in_stall_o          = fifo_full;

  der_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i && !fifo_full),
    .push_data_i(in_item),
    .full_o     (fifo_full),
    .pop_i      (pop),
    .valid_o    (fifo_valid),
    .pop_data_o (head_item)
  );

  der_parse #(
    .POSITION_BITS   (POSITION_BITS),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (total_wr),
    .total_length_i(total_q),
    .item_valid_i  (fifo_valid),
    .item_i        (head_item),
    .item_pop_o    (pop),
    .res_valid_o   (out_valid_o),
    .res_stall_i   (out_stall_i),
    .res_o         (res)
  );

  assign result_kind_o    = res.result_kind;
  assign status_o         = res.status;
  assign content_byte_o   = res.content_byte;
  assign int_value_o      = res.int_value;
  assign oid_index_o      = res.oid_index;
  assign body_length_o    = res.body_length;

endmodule

FILE: design/der_chk.sv
// Port-level checker for the DER TLV element decoder and its bind.
module der_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               result_kind_o,
  input logic [2:0]         status_o,
  input logic [7:0]         content_byte_o,
  input logic signed [63:0] int_value_o,
  input logic [3:0]         oid_index_o,
  input logic [31:0]        body_length_o
);
  import der_pkg::*;

  // A stalled result transaction stays valid and keeps its status, content byte and INTEGER value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(content_byte_o) && $stable(int_value_o))
    else $error("stalled result changed");

  // Content bytes always carry ok status, a zero INTEGER value and a zero OID index.
  a_content: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |-> status_o == ST_OK && int_value_o == 0
      && oid_index_o == '0)
    else $error("content byte with finish fields");

  // Error records carry nothing but their status.
  a_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> result_kind_o && body_length_o == '0
      && int_value_o == 0 && oid_index_o == '0 && content_byte_o == '0)
    else $error("error record with payload");

endmodule

bind der_tlv_element_decoder der_chk u_der_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_kind_o   (result_kind_o),
  .status_o        (status_o),
  .content_byte_o  (content_byte_o),
  .int_value_o     (int_value_o),
  .oid_index_o     (oid_index_o),
  .body_length_o   (body_length_o)
);
